### src/ccpp_pkg.sv
// Package with the types, codes and tag table shared by the constant pool parser.
package ccpp_pkg;

    // Parse phase of the pool stream.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TAG  = 2'd1,
        PH_BODY = 2'd2,
        PH_TEXT = 2'd3
    } phase_t;

    // Input operation codes.
    typedef enum logic {
        OP_START = 1'b0,
        OP_BYTE  = 1'b1
    } op_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_TEXT  = 2'd1,
        KIND_CONT  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // Constant pool tag codes.
    localparam logic [7:0] TAG_UTF8          = 8'd1;
    localparam logic [7:0] TAG_INTEGER       = 8'd3;
    localparam logic [7:0] TAG_FLOAT         = 8'd4;
    localparam logic [7:0] TAG_LONG          = 8'd5;
    localparam logic [7:0] TAG_DOUBLE        = 8'd6;
    localparam logic [7:0] TAG_CLASS         = 8'd7;
    localparam logic [7:0] TAG_STRING        = 8'd8;
    localparam logic [7:0] TAG_FIELDREF      = 8'd9;
    localparam logic [7:0] TAG_METHODREF     = 8'd10;
    localparam logic [7:0] TAG_IMETHODREF    = 8'd11;
    localparam logic [7:0] TAG_NAME_AND_TYPE = 8'd12;
    localparam logic [7:0] TAG_METHOD_HANDLE = 8'd15;
    localparam logic [7:0] TAG_METHOD_TYPE   = 8'd16;
    localparam logic [7:0] TAG_INVOKE_DYN    = 8'd18;

    // Depth of the result queue and width of its pointers.
    localparam int RESULT_DEPTH = 4;
    localparam int RESULT_PTR_W = 2;

    // One result transaction.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] slot;
        logic [7:0]  entry_tag;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [7:0]  text_byte;
        logic        pool_done;
    } result_t;

    // Body length in bytes of each tag; zero marks an unknown tag.
    function automatic logic [3:0] body_length(input logic [7:0] tag);
        logic [3:0] len;
        unique case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: len = 4'd2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF,
            TAG_NAME_AND_TYPE, TAG_INVOKE_DYN:                 len = 4'd4;
            TAG_LONG, TAG_DOUBLE:                              len = 4'd8;
            TAG_METHOD_HANDLE:                                 len = 4'd3;
            default:                                           len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

### src/ccpp_in_if.sv
// Input channel of the constant pool parser: start commands and pool bytes.
interface ccpp_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] slot_count;
    logic [7:0]  data_byte;

    modport source (output valid, output op, output slot_count, output data_byte,
                    input ready);
    modport sink (input valid, input op, input slot_count, input data_byte,
                  output ready);
endinterface

### src/ccpp_out_if.sv
// Result channel of the constant pool parser.
interface ccpp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] slot;
    logic [7:0]  entry_tag;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [7:0]  text_byte;
    logic        pool_done;

    modport source (output valid, output kind, output slot, output entry_tag,
                    output first_word, output second_word, output text_byte,
                    output pool_done, input ready);
    modport sink (input valid, input kind, input slot, input entry_tag,
                  input first_word, input second_word, input text_byte,
                  input pool_done, output ready);
endinterface

### src/class_constant_pool_parser.sv
// Constant pool stream parser: top level with the parse state and a four-entry result queue.
// The parser takes one transaction per clock cycle while ready: a start command or one pool byte. The
// byte that completes an entry (or a string byte, or a bad tag) writes its results into a
// four-entry result queue in the same edge, and results leave that queue in the order written.
// A Long or Double entry writes two results at once, which is why the input
// is held off whenever fewer than two queue places are free; with the result side always
// ready the queue never holds more than two results and the input runs at one byte per
// cycle.
// Slot numbers wrap within SLOT_BITS bits and the low 16 bits are reported.
module class_constant_pool_parser
    import ccpp_pkg::*;
#(
    parameter int SLOT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ccpp_in_if.sink    items,
    ccpp_out_if.source results
);

    localparam int ExtW = (SLOT_BITS > 16) ? SLOT_BITS : 16;

    // Parse state.
    phase_t                 phase_reg, phase_next;
    logic [SLOT_BITS-1:0]   slots_left_reg, slots_left_next;
    logic [SLOT_BITS-1:0]   slot_number_reg, slot_number_next;
    logic [7:0]             current_tag_reg, current_tag_next;
    logic [3:0]             body_left_reg, body_left_next;
    logic [63:0]            field_shift_reg, field_shift_next;
    logic [15:0]            text_left_reg, text_left_next;

    // Result queue.
    result_t                queue_reg [RESULT_DEPTH];
    logic [RESULT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RESULT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RESULT_PTR_W:0]   count_reg, count_next;

    logic                   accept;
    logic                   pop;
    logic [1:0]             push_count;
    result_t                res0, res1;

    logic [ExtW-1:0]        count_ext;
    logic [SLOT_BITS-1:0]   start_count;
    logic [SLOT_BITS-1:0]   slot_inc;
    logic [ExtW-1:0]        slot_cur_ext, slot_inc_ext;
    logic [15:0]            slot_cur16, slot_inc16;
    logic [SLOT_BITS-1:0]   left_after1, left_after2;
    logic [3:0]             tag_len;
    logic [3:0]             body_dec;
    logic [63:0]            shift_in;
    logic [15:0]            text_dec;

    assign accept = items.valid && items.ready;
    assign pop    = results.valid && results.ready;

    assign items.ready = (count_reg <= (RESULT_PTR_W + 1)'(RESULT_DEPTH - 2));

    assign count_ext    = ExtW'(items.slot_count);
    assign start_count  = count_ext[SLOT_BITS-1:0];
    assign slot_inc     = slot_number_reg + SLOT_BITS'(1);
    assign slot_cur_ext = ExtW'(slot_number_reg);
    assign slot_inc_ext = ExtW'(slot_inc);
    assign slot_cur16   = slot_cur_ext[15:0];
    assign slot_inc16   = slot_inc_ext[15:0];

    // Remaining slots once an entry of one or two slots has retired; stops at zero.
    assign left_after1 = (slots_left_reg > SLOT_BITS'(1)) ?
                         slots_left_reg - SLOT_BITS'(1) : '0;
    assign left_after2 = (slots_left_reg > SLOT_BITS'(2)) ?
                         slots_left_reg - SLOT_BITS'(2) : '0;

    assign tag_len  = body_length(items.data_byte);
    assign body_dec = body_left_reg - 4'd1;
    assign shift_in = {field_shift_reg[55:0], items.data_byte};
    assign text_dec = text_left_reg - 16'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        slots_left_next  = slots_left_reg;
        slot_number_next = slot_number_reg;
        current_tag_next = current_tag_reg;
        body_left_next   = body_left_reg;
        field_shift_next = field_shift_reg;
        text_left_next   = text_left_reg;
        push_count       = 2'd0;
        res0             = '0;
        res1             = '0;

        if (accept)
        begin
            if (items.op == OP_START)
            begin
                phase_next       = (start_count == '0) ? PH_IDLE : PH_TAG;
                slots_left_next  = start_count;
                slot_number_next = '0;
                current_tag_next = '0;
                body_left_next   = '0;
                field_shift_next = '0;
                text_left_next   = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_TAG:
                    begin
                        slot_number_next = slot_inc;
                        current_tag_next = items.data_byte;
                        field_shift_next = '0;
                        if (tag_len == 4'd0)
                        begin
                            res0.kind       = KIND_ERROR;
                            res0.slot       = slot_inc16;
                            res0.entry_tag  = items.data_byte;
                            res0.pool_done  = 1'b1;
                            push_count      = 2'd1;
                            phase_next      = PH_IDLE;
                            slots_left_next = '0;
                        end
                        else
                        begin
                            body_left_next = tag_len;
                            phase_next     = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        field_shift_next = shift_in;
                        body_left_next   = body_dec;
                        if (body_dec == 4'd0)
                        begin
                            res0.kind      = KIND_ENTRY;
                            res0.slot      = slot_cur16;
                            res0.entry_tag = current_tag_reg;
                            push_count     = 2'd1;
                            if (current_tag_reg == TAG_UTF8)
                            begin
                                res0.first_word = 32'(shift_in[15:0]);
                                if (shift_in[15:0] == 16'd0)
                                begin
                                    slots_left_next = left_after1;
                                    res0.pool_done  = (left_after1 == '0);
                                    phase_next      = (left_after1 == '0) ? PH_IDLE : PH_TAG;
                                end
                                else
                                begin
                                    text_left_next = shift_in[15:0];
                                    phase_next     = PH_TEXT;
                                end
                            end
                            else if (current_tag_reg == TAG_LONG ||
                                     current_tag_reg == TAG_DOUBLE)
                            begin
                                // A wide entry also takes the following, unusable slot.
                                res0.first_word  = shift_in[63:32];
                                res0.second_word = shift_in[31:0];
                                res1.kind        = KIND_CONT;
                                res1.slot        = slot_inc16;
                                res1.entry_tag   = current_tag_reg;
                                res1.pool_done   = (left_after2 == '0);
                                push_count       = 2'd2;
                                slot_number_next = slot_inc;
                                slots_left_next  = left_after2;
                                phase_next       = (left_after2 == '0) ? PH_IDLE : PH_TAG;
                            end
                            else
                            begin
                                if (current_tag_reg == TAG_INTEGER ||
                                    current_tag_reg == TAG_FLOAT)
                                begin
                                    res0.first_word = shift_in[31:0];
                                end
                                else if (current_tag_reg == TAG_METHOD_HANDLE)
                                begin
                                    res0.first_word  = 32'(shift_in[23:16]);
                                    res0.second_word = 32'(shift_in[15:0]);
                                end
                                else if (current_tag_reg == TAG_FIELDREF ||
                                         current_tag_reg == TAG_METHODREF ||
                                         current_tag_reg == TAG_IMETHODREF ||
                                         current_tag_reg == TAG_NAME_AND_TYPE ||
                                         current_tag_reg == TAG_INVOKE_DYN)
                                begin
                                    res0.first_word  = 32'(shift_in[31:16]);
                                    res0.second_word = 32'(shift_in[15:0]);
                                end
                                else
                                begin
                                    res0.first_word = 32'(shift_in[15:0]);
                                end
                                slots_left_next = left_after1;
                                res0.pool_done  = (left_after1 == '0);
                                phase_next      = (left_after1 == '0) ? PH_IDLE : PH_TAG;
                            end
                        end
                    end
                    PH_TEXT:
                    begin
                        text_left_next = text_dec;
                        res0.kind      = KIND_TEXT;
                        res0.slot      = slot_cur16;
                        res0.entry_tag = current_tag_reg;
                        res0.text_byte = items.data_byte;
                        push_count     = 2'd1;
                        if (text_dec == 16'd0)
                        begin
                            slots_left_next = left_after1;
                            res0.pool_done  = (left_after1 == '0);
                            phase_next      = (left_after1 == '0) ? PH_IDLE : PH_TAG;
                        end
                    end
                    PH_IDLE:
                    begin
                        // Bytes outside a pool are dropped.
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RESULT_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + RESULT_PTR_W'(pop);
        count_next  = count_reg + (RESULT_PTR_W + 1)'(push_count)
                      - (RESULT_PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            slots_left_reg  <= '0;
            slot_number_reg <= '0;
            current_tag_reg <= '0;
            body_left_reg   <= '0;
            field_shift_reg <= '0;
            text_left_reg   <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            slots_left_reg  <= slots_left_next;
            slot_number_reg <= slot_number_next;
            current_tag_reg <= current_tag_next;
            body_left_reg   <= body_left_next;
            field_shift_reg <= field_shift_next;
            text_left_reg   <= text_left_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
        end
    end

    // Queue storage holds payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_count == 2'd2)
        begin
            queue_reg[wr_ptr_reg + RESULT_PTR_W'(1)] <= res1;
        end
    end

    assign results.valid       = (count_reg != '0);
    assign results.kind        = queue_reg[rd_ptr_reg].kind;
    assign results.slot        = queue_reg[rd_ptr_reg].slot;
    assign results.entry_tag   = queue_reg[rd_ptr_reg].entry_tag;
    assign results.first_word  = queue_reg[rd_ptr_reg].first_word;
    assign results.second_word = queue_reg[rd_ptr_reg].second_word;
    assign results.text_byte   = queue_reg[rd_ptr_reg].text_byte;
    assign results.pool_done   = queue_reg[rd_ptr_reg].pool_done;

endmodule

### src/ccpp_checker.sv
// Port-level checks for the constant pool parser, bound to its top level.
module ccpp_checker
    import ccpp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [15:0] out_slot,
    input logic [31:0] out_first_word,
    input logic [31:0] out_second_word,
    input logic [7:0]  out_text_byte,
    input logic        out_pool_done
);

    // A result held back by the sink keeps its slot and words.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_slot) &&
            $stable(out_first_word) && $stable(out_second_word))
        else $error("stalled result changed");

    // A bad tag always closes the pool.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_ERROR |-> out_pool_done)
        else $error("error result without pool_done");

    // String bytes, continuations and errors carry no words.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_ENTRY |-> out_first_word == '0 &&
            out_second_word == '0)
        else $error("words set on a non-entry result");

    // Only a string byte result carries a text byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_TEXT |-> out_text_byte == '0)
        else $error("text byte outside a string result");

    // A start command on an empty queue produces no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_op == OP_START && !out_valid |=> !out_valid)
        else $error("result after a start command");

endmodule

bind class_constant_pool_parser ccpp_checker u_ccpp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (items.valid),
    .in_ready        (items.ready),
    .in_op           (items.op),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .out_kind        (results.kind),
    .out_slot        (results.slot),
    .out_first_word  (results.first_word),
    .out_second_word (results.second_word),
    .out_text_byte   (results.text_byte),
    .out_pool_done   (results.pool_done)
);
